[rtl/core/hav_pkg.sv]
// Shared constants, widths and the arctangent table for the haversine distance pipeline.
package hav_pkg;

  // Default CORDIC depth (one pipeline stage per iteration)
  localparam int CORDIC_ITERS_DEF = 24;

  // Port widths
  localparam int LAT_W  = 31;
  localparam int LON_W  = 32;
  localparam int DIST_W = 31;
  localparam int IN_W   = 128;
  localparam int OUT_W  = 32;

  // Internal widths
  localparam int ANG_W  = 35;  // angle in degrees * 2^24, before wrap
  localparam int MAG_W  = 31;  // folded angle magnitude
  localparam int K_W    = 33;  // degree-to-radian constant
  localparam int CW     = 34;  // CORDIC x, y, z
  localparam int QW     = 33;  // Q30 products after rounding
  localparam int SR_W   = 61;  // square root radicand / remainder
  localparam int RT_W   = 31;  // square root result
  localparam int SQ_STEPS = 31; // one result bit per stage
  localparam int DP_W   = 45;  // angle times diameter

  // Angle constants, degrees * 2^24
  localparam logic signed [ANG_W-1:0] FULL_TURN    = 35'sd6039797760;
  localparam logic signed [ANG_W-1:0] HALF_TURN    = 35'sd3019898880;
  localparam logic signed [ANG_W-1:0] QUARTER_TURN = 35'sd1509949440;

  // round(pi/180 * 2^38)
  localparam logic [K_W-1:0] DEG_TO_RAD = 33'd4797524517;

  // Q30 constants
  localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;
  localparam logic [MAG_W-1:0]     Q30_ONE  = 31'd1073741824;
  localparam int                   Q30_HALF = 536870912;

  // Distance scaling
  localparam logic [13:0]         DIAMETER_KM   = 14'd12742;
  localparam logic [DIST_W-1:0]   HALF_CIRC_Q16 = 31'd1311708728;

  // atan(2^-i) in Q30
  localparam logic signed [CW-1:0] ATAN_TAB [32] = '{
    34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
    34'sd67021686,  34'sd33543515,  34'sd16775850,  34'sd8388437,
    34'sd4194282,   34'sd2097149,   34'sd1048575,   34'sd524287,
    34'sd262143,    34'sd131071,    34'sd65535,     34'sd32767,
    34'sd16383,     34'sd8191,      34'sd4095,      34'sd2047,
    34'sd1023,      34'sd511,       34'sd255,       34'sd127,
    34'sd63,        34'sd31,        34'sd15,        34'sd8,
    34'sd4,         34'sd2,         34'sd1,         34'sd0
  };

endpackage

[rtl/core/haversine_distance_top.sv]
// Pipelined haversine great-circle distance between two points given in degrees.
//
//  channel  | dir | payload (tdata, low bit first)                    | handshake
//  s_axis   | in  | first_lat[30:0] first_lon[62:31] second_lat[93:63] | tvalid/tready
//           |     | second_lon[125:94], zero fill [127:126]            |
//  m_axis   | out | distance_km[30:0], zero fill [31]                  | tvalid/tready
//
// One point pair per cycle while the output buffer is not full. An input beat passes
// through two CORDIC chains, a 31-stage square root, 9 other stages, and the output
// buffer on its way to the result beat. rst clears the valid bits and the output buffer count.
// The pipeline advances as one; it holds only while the two-entry output buffer is
// full, so an input beat is still taken while one result waits.
module haversine_distance_top
  import hav_pkg::*;
#(
  parameter int CORDIC_ITERATIONS = CORDIC_ITERS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // first_latitude, first_longitude, second_latitude, second_longitude
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // distance_km
  output logic [OUT_W-1:0] m_axis_tdata
);

  localparam int NI  = CORDIC_ITERATIONS;
  localparam int LAT = 4 + NI + 3 + SQ_STEPS + NI + 2;
  localparam logic [1:0] SKID_EMPTY = 2'd0;
  localparam logic [1:0] SKID_ONE   = 2'd1;
  localparam logic [1:0] SKID_FULL  = 2'd2;

  logic           en;
  logic [LAT-1:0] vld;
  logic [1:0]     cnt;

  // global advance: only a full output buffer stops the pipe
  assign en            = (cnt != SKID_FULL);
  assign s_axis_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_axis_tvalid & en};
    end
  end

  // ---------------- S1: angle differences and doubled latitudes
  logic signed [LAT_W-1:0] lat1, lat2;
  logic signed [LON_W-1:0] lon1, lon2;
  logic signed [ANG_W-1:0] ang_c [4];
  logic signed [ANG_W-1:0] ang_s1 [4];

  assign lat1 = s_axis_tdata[30:0];
  assign lon1 = s_axis_tdata[62:31];
  assign lat2 = s_axis_tdata[93:63];
  assign lon2 = s_axis_tdata[125:94];

  // lane 0: dlat/2, lane 1: dlon/2, lane 2: lat1, lane 3: lat2 (2^24 units)
  assign ang_c[0] = ANG_W'(lat2) - ANG_W'(lat1);
  assign ang_c[1] = ANG_W'(lon2) - ANG_W'(lon1);
  assign ang_c[2] = ANG_W'(lat1) + ANG_W'(lat1);
  assign ang_c[3] = ANG_W'(lat2) + ANG_W'(lat2);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) ang_s1[l] <= ang_c[l];
    end
  end

  // ---------------- S2: wrap to half turn, fold to quarter turn
  logic [MAG_W-1:0] mag_c [4];
  logic [3:0]       neg_c, flip_c;
  logic [MAG_W-1:0] mag_s2 [4];
  logic [3:0]       neg_s2, flip_s2;

  always_comb begin
    logic signed [ANG_W-1:0] w;
    for (int l = 0; l < 4; l++) begin
      w = ang_s1[l];
      if (w >= HALF_TURN) begin
        w = w - FULL_TURN;
      end else if (w < -HALF_TURN) begin
        w = w + FULL_TURN;
      end
      flip_c[l] = 1'b0;
      if (w > QUARTER_TURN) begin
        w = w - HALF_TURN;
        flip_c[l] = 1'b1;
      end else if (w < -QUARTER_TURN) begin
        w = w + HALF_TURN;
        flip_c[l] = 1'b1;
      end
      neg_c[l] = w[ANG_W-1];
      mag_c[l] = w[ANG_W-1] ? MAG_W'(-w) : MAG_W'(w);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) mag_s2[l] <= mag_c[l];
      neg_s2  <= neg_c;
      flip_s2 <= flip_c;
    end
  end

  // ---------------- S3: radian conversion, partial products
  logic [47:0] ph_s3 [4];
  logic [48:0] pl_s3 [4];
  logic [3:0]  neg_s3, flip_s3;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        ph_s3[l] <= 48'(mag_s2[l][30:16]) * 48'(DEG_TO_RAD);
        pl_s3[l] <= 49'(mag_s2[l][15:0]) * 49'(DEG_TO_RAD);
      end
      neg_s3  <= neg_s2;
      flip_s3 <= flip_s2;
    end
  end

  // ---------------- S4: sum, round, restore sign
  logic [64:0]            rsum [4];
  logic signed [CW-1:0]   z_s4 [4];
  logic [1:0]             flip_s4;

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      rsum[l] = {1'b0, ph_s3[l], 16'b0} + 65'(pl_s3[l]) + 65'(32'h8000_0000);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < 4; l++) begin
        z_s4[l] <= neg_s3[l] ? -CW'(rsum[l][62:32]) : CW'(rsum[l][62:32]);
      end
      flip_s4 <= flip_s3[3:2];
    end
  end

  // ---------------- rotation CORDIC, one iteration per stage, four lanes
  logic signed [CW-1:0] rx [1:NI][4];
  logic signed [CW-1:0] ry [1:NI][4];
  logic signed [CW-1:0] rz [1:NI][4];
  logic [1:0]           rfl [1:NI];

  for (genvar i = 0; i < NI; i++) begin : g_rot
    logic signed [CW-1:0] xi [4];
    logic signed [CW-1:0] yi [4];
    logic signed [CW-1:0] zi [4];
    logic [1:0]           fi;

    if (i == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < 4; l++) begin
          xi[l] = GAIN_INV;
          yi[l] = '0;
          zi[l] = z_s4[l];
        end
      end
      assign fi = flip_s4;
    end else begin : g_next
      always_comb begin
        for (int l = 0; l < 4; l++) begin
          xi[l] = rx[i][l];
          yi[l] = ry[i][l];
          zi[l] = rz[i][l];
        end
      end
      assign fi = rfl[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int l = 0; l < 4; l++) begin
          if (!zi[l][CW-1]) begin
            rx[i+1][l] <= xi[l] - (yi[l] >>> i);
            ry[i+1][l] <= yi[l] + (xi[l] >>> i);
            rz[i+1][l] <= zi[l] - ATAN_TAB[i];
          end else begin
            rx[i+1][l] <= xi[l] + (yi[l] >>> i);
            ry[i+1][l] <= yi[l] - (xi[l] >>> i);
            rz[i+1][l] <= zi[l] + ATAN_TAB[i];
          end
        end
        rfl[i+1] <= fi;
      end
    end
  end

  // ---------------- P1: squares of half-angle sines, cosine product
  localparam logic signed [2*CW-1:0] RND_P1 = (2*CW)'(Q30_HALF);
  localparam logic signed [2*QW-1:0] RND_P2 = (2*QW)'(Q30_HALF);

  logic signed [CW-1:0]   c1m;
  logic signed [2*CW-1:0] p_lat, p_lon, p_cc;
  logic signed [QW-1:0]   sq_lat_p1, sq_lon_p1, cc_p1;

  // cosine sign from the two folds
  assign c1m   = (rfl[NI][0] ^ rfl[NI][1]) ? -rx[NI][2] : rx[NI][2];
  assign p_lat = (2*CW)'(ry[NI][0]) * (2*CW)'(ry[NI][0]);
  assign p_lon = (2*CW)'(ry[NI][1]) * (2*CW)'(ry[NI][1]);
  assign p_cc  = (2*CW)'(c1m) * (2*CW)'(rx[NI][3]);

  always_ff @(posedge clk) begin
    if (en) begin
      sq_lat_p1 <= QW'((p_lat + RND_P1) >>> 30);
      sq_lon_p1 <= QW'((p_lon + RND_P1) >>> 30);
      cc_p1     <= QW'((p_cc + RND_P1) >>> 30);
    end
  end

  // ---------------- P2: cos*cos*sin^2(dlon/2)
  logic signed [2*QW-1:0] p_t;
  logic signed [QW-1:0]   t_p2, sq_lat_p2;

  assign p_t = (2*QW)'(cc_p1) * (2*QW)'(sq_lon_p1);

  always_ff @(posedge clk) begin
    if (en) begin
      t_p2      <= QW'((p_t + RND_P2) >>> 30);
      sq_lat_p2 <= sq_lat_p1;
    end
  end

  // ---------------- P3: a, clamped to [0,1]; radicands of both roots
  logic signed [QW:0]  a_sum;
  logic [MAG_W-1:0]    a_c;
  logic [SR_W-1:0]     sq_init [2];

  assign a_sum = (QW+1)'(sq_lat_p2) + (QW+1)'(t_p2);

  always_comb begin
    if (a_sum[QW]) begin
      a_c = '0;
    end else if (a_sum > (QW+1)'(Q30_ONE)) begin
      a_c = Q30_ONE;
    end else begin
      a_c = a_sum[MAG_W-1:0];
    end
  end

  // index 0: 1-a, index 1: a
  always_ff @(posedge clk) begin
    if (en) begin
      sq_init[0] <= {Q30_ONE - a_c, 30'b0};
      sq_init[1] <= {a_c, 30'b0};
    end
  end

  // ---------------- square roots, one result bit per stage
  logic [SR_W-1:0] sq_rem  [1:SQ_STEPS-1][2];
  logic [RT_W-1:0] sq_root [1:SQ_STEPS][2];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    localparam int B = SQ_STEPS - 1 - k;
    logic [SR_W-1:0] rin [2];
    logic [RT_W-1:0] qin [2];
    logic [SR_W:0]   tst [2];
    logic [1:0]      ge;

    if (k == 0) begin : g_first
      always_comb begin
        for (int j = 0; j < 2; j++) begin
          rin[j] = sq_init[j];
          qin[j] = '0;
        end
      end
    end else begin : g_next
      always_comb begin
        for (int j = 0; j < 2; j++) begin
          rin[j] = sq_rem[k][j];
          qin[j] = sq_root[k][j];
        end
      end
    end

    // trial subtrahend 2*root*2^B + 2^(2B)
    always_comb begin
      for (int j = 0; j < 2; j++) begin
        tst[j] = ((SR_W+1)'(qin[j]) << (B + 1)) + ((SR_W+1)'(1) << (2 * B));
        ge[j]  = ({1'b0, rin[j]} >= tst[j]);
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        for (int j = 0; j < 2; j++) begin
          sq_root[k+1][j] <= ge[j] ? (qin[j] | (RT_W'(1) << B)) : qin[j];
        end
      end
    end

    if (k < SQ_STEPS - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          for (int j = 0; j < 2; j++) begin
            sq_rem[k+1][j] <= ge[j] ? (rin[j] - tst[j][SR_W-1:0]) : rin[j];
          end
        end
      end
    end
  end

  // ---------------- vectoring CORDIC on (sqrt(1-a), sqrt(a))
  logic signed [CW-1:0] vx [1:NI];
  logic signed [CW-1:0] vy [1:NI];
  logic signed [CW-1:0] vz [1:NI];

  for (genvar i = 0; i < NI; i++) begin : g_vec
    logic signed [CW-1:0] xi, yi, zi;

    if (i == 0) begin : g_first
      assign xi = CW'(sq_root[SQ_STEPS][0]);
      assign yi = CW'(sq_root[SQ_STEPS][1]);
      assign zi = '0;
    end else begin : g_next
      assign xi = vx[i];
      assign yi = vy[i];
      assign zi = vz[i];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (!yi[CW-1]) begin
          vx[i+1] <= xi + (yi >>> i);
          vy[i+1] <= yi - (xi >>> i);
          vz[i+1] <= zi + ATAN_TAB[i];
        end else begin
          vx[i+1] <= xi - (yi >>> i);
          vy[i+1] <= yi + (xi >>> i);
          vz[i+1] <= zi - ATAN_TAB[i];
        end
      end
    end
  end

  // ---------------- D1: half angle times diameter
  logic [MAG_W-1:0] zc;
  logic [DP_W-1:0]  prod_d1;

  assign zc = vz[NI][CW-1] ? '0 : vz[NI][MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      prod_d1 <= DP_W'(zc) * DP_W'(DIAMETER_KM);
    end
  end

  // ---------------- D2: round to Q16 and saturate
  logic [DP_W:0]     dsum;
  logic [31:0]       dq;
  logic [DIST_W-1:0] dist_d2;

  assign dsum = (DP_W+1)'(prod_d1) + (DP_W+1)'(14'h2000);
  assign dq   = dsum[45:14];

  always_ff @(posedge clk) begin
    if (en) begin
      dist_d2 <= (dq > 32'(HALF_CIRC_Q16)) ? HALF_CIRC_Q16 : dq[DIST_W-1:0];
    end
  end

  // ---------------- two-entry output buffer
  logic              push, pop;
  logic [DIST_W-1:0] q0, q1;

  assign push = en & vld[LAT-1];
  assign pop  = m_axis_tvalid & m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= SKID_EMPTY;
    end else begin
      case (cnt)
        SKID_EMPTY: if (push) cnt <= SKID_ONE;
        SKID_ONE: begin
          if (push && !pop) begin
            cnt <= SKID_FULL;
          end else if (!push && pop) begin
            cnt <= SKID_EMPTY;
          end
        end
        SKID_FULL:  if (pop) cnt <= SKID_ONE;
        default:    cnt <= SKID_EMPTY;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cnt)
      SKID_EMPTY: if (push) q0 <= dist_d2;
      SKID_ONE: begin
        if (push && pop) begin
          q0 <= dist_d2;
        end else if (push) begin
          q1 <= dist_d2;
        end
      end
      SKID_FULL:  if (pop) q0 <= q1;
      default:    q0 <= q0;
    endcase
  end

  assign m_axis_tvalid = (cnt != SKID_EMPTY);
  assign m_axis_tdata  = {1'b0, q0};

endmodule

[rtl/core/hav_chk.sv]
// Port-level checks for the haversine distance top level, bound to it.
module hav_chk
  import hav_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  // a stalled result beat holds its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // distance never passes half the circumference, pad bit stays clear
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[DIST_W-1:0] <= HALF_CIRC_Q16) && !m_axis_tdata[OUT_W-1])
    else $error("distance out of range");

  // input side only backs up when two results are waiting
  a_ready_low: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no result pending");

  // reset empties the output buffer
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid && s_axis_tready)
    else $error("output not empty after reset");

endmodule

bind haversine_distance_top hav_chk u_hav_chk (.*);

[tb/sv/hav_checker.sv]
// Checker for the haversine distance pipeline: predicts each distance and compares it.
module hav_checker
  import hav_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_axis_tvalid,
  input  logic             s_axis_tready,
  input  logic [IN_W-1:0]  s_axis_tdata,
  input  logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  input  logic [OUT_W-1:0] m_axis_tdata,
  output int               errors,
  output int               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = (CORDIC_ITERS_DEF > 32) ? 32 : CORDIC_ITERS_DEF;

  logic [DIST_W-1:0] dist_queue[$];
  int                beats_out;

  // Sine and cosine of an angle in degrees * 2^24, Q30
  task automatic trig(input longint ang, output longint cs, output longint sn);
    longint            r, x, y, z, nx;
    longint unsigned   mag;
    bit                flip;
    r    = ang % longint'(FULL_TURN);
    flip = 0;
    if (r < 0) r += longint'(FULL_TURN);
    if (r >= longint'(HALF_TURN)) r -= longint'(FULL_TURN);
    // fold into [-90, 90] degrees, negate the result afterwards
    if (r > longint'(QUARTER_TURN)) begin
      r -= longint'(HALF_TURN);
      flip = 1;
    end else if (r < -longint'(QUARTER_TURN)) begin
      r += longint'(HALF_TURN);
      flip = 1;
    end
    mag = (r < 0) ? longint'(-r) : longint'(r);
    mag = (mag * longint'(DEG_TO_RAD) + 64'd2147483648) >> 32;
    z = (r < 0) ? -longint'(mag) : longint'(mag);
    x = longint'(GAIN_INV);
    y = 0;
    // rotation mode
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ATAN_TAB[i]);
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endtask

  function automatic longint unsigned int_root(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b   = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v   = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint q30_round(longint p);
    return (p + longint'(Q30_HALF)) >>> 30;
  endfunction

  task automatic predict_distance(input logic [IN_W-1:0] d, output logic [DIST_W-1:0] km);
    longint lat1, lon1, lat2, lon2;
    longint c1, s1, c2, s2, ch, sh, cl, sl;
    longint sq_lat, sq_lon, cc, a, x, y, z, nx, dist_km;
    lat1 = longint'(signed'(d[30:0]));
    lon1 = longint'(signed'(d[62:31]));
    lat2 = longint'(signed'(d[93:63]));
    lon2 = longint'(signed'(d[125:94]));
    // a 2^23 difference read in 2^24 units is the half-difference
    trig(lat2 - lat1, ch, sh);
    trig(lon2 - lon1, cl, sl);
    trig(lat1 * 2, c1, s1);
    trig(lat2 * 2, c2, s2);
    sq_lat = q30_round(sh * sh);
    sq_lon = q30_round(sl * sl);
    cc     = q30_round(c1 * c2);
    a      = sq_lat + q30_round(cc * sq_lon);
    if (a < 0) a = 0;
    if (a > longint'(Q30_ONE)) a = longint'(Q30_ONE);
    y = longint'(int_root(longint'(a) << 30));
    x = longint'(int_root((longint'(Q30_ONE) - a) << 30));
    z = 0;
    // vectoring mode gives the half angle
    for (int i = 0; i < STEPS; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + longint'(ATAN_TAB[i]);
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - longint'(ATAN_TAB[i]);
      end
      x = nx;
    end
    if (z < 0) z = 0;
    dist_km = (z * longint'(DIAMETER_KM) + (64'sd1 <<< 13)) >>> 14;
    if (dist_km > longint'(HALF_CIRC_Q16)) dist_km = longint'(HALF_CIRC_Q16);
    km = dist_km[DIST_W-1:0];
  endtask

  task automatic report(input string what, input longint got, input longint want);
    $display("MISMATCH beat %0d: %s got %0d expected %0d", beats_out, what, got, want);
    errors++;
  endtask

  initial pending = 0;

  // Predict on input beats, compare on output beats
  always @(posedge clk) begin
    logic [DIST_W-1:0] km;
    if (rst) begin
      errors    = 0;
      beats_out = 0;
      dist_queue.delete();
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_distance(s_axis_tdata, km);
        dist_queue.push_back(km);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (dist_queue.size() == 0) begin
          report("unexpected beat, distance_km", m_axis_tdata[DIST_W-1:0], -1);
        end else begin
          km = dist_queue.pop_front();
          if (m_axis_tdata[DIST_W-1:0] !== km)
            report("distance_km", m_axis_tdata[DIST_W-1:0], km);
        end
        beats_out++;
      end
    end
    pending = dist_queue.size();
  end

endmodule

[tb/sv/tb_haversine_distance_top.sv]
// Testbench top for the haversine distance pipeline: stimulus, back-pressure and verdict.
module tb_haversine_distance_top;
  import hav_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint LAT_MAX  = 754974720;   // 90 degrees
  localparam longint LON_MAX  = 1509949440;  // 180 degrees
  localparam int     RAND_PAIRS = 1030;
  localparam int     LIMIT    = 400000;

  logic             clk = 0;
  logic             rst = 1;
  logic             s_axis_tvalid = 0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 0;
  logic [OUT_W-1:0] m_axis_tdata;

  int  errors, pending;
  int  cycles = 0;
  int  hold_cycles = 0;
  bit  rx_fast = 0;
  bit  tx_fast = 0;
  int  pairs_sent = 0;

  always #2 clk = ~clk;

  haversine_distance_top u_top (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  hav_checker u_chk (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .errors(errors), .pending(pending)
  );

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d distances outstanding", cycles, pending);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Send one point pair as a beat
  task automatic send_pair(input longint lat1, input longint lon1,
                           input longint lat2, input longint lon2);
    int gap;
    gap = tx_fast ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= {2'b00, lon2[31:0], lat2[30:0], lon1[31:0], lat1[30:0]};
    do @(posedge clk); while (!s_axis_tready);
    pairs_sent++;
  endtask

  function automatic longint rand_span(longint lim);
    return longint'($urandom_range(0, 32'(2 * lim))) - lim;
  endfunction

  function automatic longint rand_bits(int w);
    logic [31:0] r;
    r = $urandom();
    return (w == 31) ? longint'(signed'(r[30:0])) : longint'(signed'(r));
  endfunction

  // Result side: random stalls, optional long hold-off
  initial begin
    int stall;
    wait (!rst);
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      stall = rx_fast ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_axis_tready <= 0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1;
      do @(posedge clk); while (!m_axis_tvalid);
    end
  end

  initial begin
    longint lat1, lon1, lat2, lon2;
    int     kind;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: zero, same point, extremes, poles, antipodes, out-of-range angles
    send_pair(0, 0, 0, 0);
    send_pair(LAT_MAX / 3, LON_MAX / 5, LAT_MAX / 3, LON_MAX / 5);
    send_pair(LAT_MAX, 0, -LAT_MAX, 0);
    send_pair(LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
    send_pair(0, 0, 0, LON_MAX);
    send_pair(0, -LON_MAX, 0, LON_MAX);
    send_pair(0, LON_MAX, 0, 0);
    send_pair(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
    send_pair(LAT_MAX / 2, LON_MAX / 4, -LAT_MAX / 2, LON_MAX / 4 - LON_MAX);
    send_pair(LAT_MAX / 2, LON_MAX / 4, -LAT_MAX / 2, LON_MAX / 4 - LON_MAX + 1);
    send_pair(0, 0, 0, 1);
    send_pair(1, 0, 0, 0);
    send_pair(-(64'sd1 << 30), -(64'sd1 << 31), (64'sd1 << 30) - 1, (64'sd1 << 31) - 1);
    send_pair((64'sd1 << 30) - 1, (64'sd1 << 31) - 1, -(64'sd1 << 30), -(64'sd1 << 31));
    send_pair(-1, -1, -1, -1);
    send_pair(LAT_MAX + 8388608, 0, 0, 0);
    send_pair(-LAT_MAX - 100, LON_MAX + 12345, LAT_MAX + 77, -LON_MAX - 999);
    send_pair(0, 0, 2 * LAT_MAX, 0);
    send_pair(LAT_MAX - 1, 17, LAT_MAX - 1, 17 + LON_MAX);
    send_pair(12345678, -87654321, 12345679, -87654320);

    // random pairs, with one long hold-off and one drain
    for (int n = 0; n < RAND_PAIRS; n++) begin
      if (n % 90 == 0) begin
        rx_fast = ($urandom_range(0, 3) == 0);
        tx_fast = ($urandom_range(0, 3) == 0);
      end
      if (n == 200) hold_cycles = 600;
      if (n == 500) begin
        s_axis_tvalid <= 0;
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      kind = $urandom_range(0, 9);
      lat1 = rand_span(LAT_MAX);
      lon1 = rand_span(LON_MAX);
      if (kind < 5) begin
        lat2 = rand_span(LAT_MAX);
        lon2 = rand_span(LON_MAX);
      end else if (kind < 7) begin
        // near-antipodal
        lat2 = -lat1 + longint'($urandom_range(0, 2000)) - 1000;
        lon2 = (lon1 >= 0 ? lon1 - LON_MAX : lon1 + LON_MAX)
               + longint'($urandom_range(0, 2000)) - 1000;
        if (lat2 > LAT_MAX) lat2 = LAT_MAX;
        if (lat2 < -LAT_MAX) lat2 = -LAT_MAX;
      end else if (kind < 8) begin
        // nearby points
        lat2 = lat1 + longint'($urandom_range(0, 200000)) - 100000;
        lon2 = lon1 + longint'($urandom_range(0, 200000)) - 100000;
        if (lat2 > LAT_MAX) lat2 = LAT_MAX;
        if (lon2 > LON_MAX) lon2 = LON_MAX;
      end else begin
        // any value the field widths allow
        lat1 = rand_bits(31);
        lon1 = rand_bits(32);
        lat2 = rand_bits(31);
        lon2 = rand_bits(32);
      end
      send_pair(lat1, lon1, lat2, lon2);
    end
    s_axis_tvalid <= 0;

    @(posedge clk);
    wait (pending == 0);
    repeat (120) @(posedge clk);
    $display("Sent %0d point pairs: poles, antipodes, out-of-range angles, random spans,",
             pairs_sent);
    $display("with random gaps on both sides, a long output hold-off and a full drain.");
    if (errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
